// ----- sv/mqrb_pkg.sv -----
package mqrb_pkg;

  // Pool geometry
  localparam int QUEUE_DEPTH = 128;
  localparam int QUEUE_COUNT = 8;
  localparam int WORD_WIDTH  = 16;

  // Derived widths
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QID_W   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int STORE_DEPTH = QUEUE_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);

  // Field widths of the ports
  localparam int REQ_W    = 2;
  localparam int QUEUE_W  = 8;
  localparam int STATUS_W = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_OPEN = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd2;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_QUEUE = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

endpackage

// ----- sv/mqrb_ram.sv -----
module mqrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/multi_queue_ring_buffer_pool.sv -----
// Channel   Direction  Handshake                 Word
// request   in         in_valid_i / in_ready_o   req_type_i, queue_id_i, write_data_i
// response  out        out_valid_o / out_ready_i status_o, read_data_o
//
// Each request does pointer lookup, status and the store access in the accept cycle,
// and the registered store read in the next. A new request is not taken while one is
// pending, so only one request is in flight at a time.
// Reset empties every queue at once (pointers and counts are flops); the store is not
// cleared. A stalled response holds in the output register and blocks new requests.
module multi_queue_ring_buffer_pool (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mqrb_pkg::REQ_W-1:0]       req_type_i,
  input  logic [mqrb_pkg::QUEUE_W-1:0]     queue_id_i,
  input  logic [mqrb_pkg::WORD_WIDTH-1:0]  write_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mqrb_pkg::STATUS_W-1:0]    status_o,
  output logic [mqrb_pkg::WORD_WIDTH-1:0]  read_data_o
);

  localparam int PTR_W  = mqrb_pkg::PTR_W;
  localparam int FILL_W = mqrb_pkg::FILL_W;
  localparam int ADDR_W = mqrb_pkg::ADDR_W;
  localparam int QID_W  = mqrb_pkg::QID_W;

  // Per-queue control state
  logic [PTR_W-1:0]  wptr_q [mqrb_pkg::QUEUE_COUNT];
  logic [PTR_W-1:0]  rptr_q [mqrb_pkg::QUEUE_COUNT];
  logic [FILL_W-1:0] fill_q [mqrb_pkg::QUEUE_COUNT];

  // Pending stage and output register
  logic                          pend_q;
  mqrb_pkg::status_e             pend_status_q;
  logic                          pend_pop_q;
  logic                          out_valid_q;
  mqrb_pkg::status_e             status_q;
  logic [mqrb_pkg::WORD_WIDTH-1:0] read_data_q;

  logic                          accept;
  logic                          qid_ok;
  logic [QID_W-1:0]              qidx;
  logic [PTR_W-1:0]              cur_wptr, cur_rptr;
  logic [FILL_W-1:0]             cur_fill;
  logic                          is_full, is_empty;
  logic                          do_open, do_push, do_pop;
  mqrb_pkg::status_e             status_d;
  logic [ADDR_W-1:0]             waddr, raddr;
  logic [mqrb_pkg::WORD_WIDTH-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(mqrb_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Handshake: one request in flight, output must be free by the time it lands
  assign in_ready_o = !pend_q && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Lookup of the addressed queue
  assign qid_ok   = queue_id_i < mqrb_pkg::QUEUE_W'(mqrb_pkg::QUEUE_COUNT);
  assign qidx     = queue_id_i[QID_W-1:0];
  assign cur_wptr = wptr_q[qidx];
  assign cur_rptr = rptr_q[qidx];
  assign cur_fill = fill_q[qidx];
  assign is_full  = cur_fill == FILL_W'(mqrb_pkg::QUEUE_DEPTH);
  assign is_empty = cur_fill == '0;

  // Decode request into an action and a status
  always_comb begin
    do_open  = 1'b0;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    status_d = mqrb_pkg::ST_DONE;
    if (!qid_ok) begin
      status_d = mqrb_pkg::ST_BAD_QUEUE;
    end else begin
      unique case (req_type_i)
        mqrb_pkg::REQ_OPEN: do_open = 1'b1;
        mqrb_pkg::REQ_PUSH: begin
          if (is_full) status_d = mqrb_pkg::ST_FULL;
          else         do_push  = 1'b1;
        end
        mqrb_pkg::REQ_POP: begin
          if (is_empty) status_d = mqrb_pkg::ST_EMPTY;
          else          do_pop   = 1'b1;
        end
        default: ;  // unused code: no action
      endcase
    end
  end

  // Store addresses: queue base plus slot
  assign waddr = ADDR_W'(qidx) * ADDR_W'(mqrb_pkg::QUEUE_DEPTH) + ADDR_W'(cur_wptr);
  assign raddr = ADDR_W'(qidx) * ADDR_W'(mqrb_pkg::QUEUE_DEPTH) + ADDR_W'(cur_rptr);

  mqrb_ram #(
    .WIDTH(mqrb_pkg::WORD_WIDTH),
    .DEPTH(mqrb_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (accept && do_push),
    .waddr_i(waddr),
    .wdata_i(write_data_i),
    .re_i   (accept && do_pop),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // Pointer and fill count update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mqrb_pkg::QUEUE_COUNT; i++) begin
        wptr_q[i] <= '0;
        rptr_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (accept) begin
      if (do_open) begin
        wptr_q[qidx] <= '0;
        rptr_q[qidx] <= '0;
        fill_q[qidx] <= '0;
      end else if (do_push) begin
        wptr_q[qidx] <= wrap_next(cur_wptr);
        fill_q[qidx] <= cur_fill + FILL_W'(1);
      end else if (do_pop) begin
        rptr_q[qidx] <= wrap_next(cur_rptr);
        fill_q[qidx] <= cur_fill - FILL_W'(1);
      end
    end
  end

  // Pending stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_status_q <= status_d;
      pend_pop_q    <= do_pop;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      status_q    <= pend_status_q;
      read_data_q <= pend_pop_q ? ram_rdata : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign read_data_o = read_data_q;

`ifndef NO_ASSERTIONS
  // A response only appears right after a pending request
  a_rose_after_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pend_q))
    else $error("response without pending request");

  // The pending request never finds the output register occupied
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("output register overwritten");

  // No request taken while one is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_ready_o)
    else $error("request taken while pending");

  // Fill count of the addressed queue never exceeds the depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && qid_ok |-> cur_fill <= FILL_W'(mqrb_pkg::QUEUE_DEPTH))
    else $error("fill count overflow");

  // Only a successful pop carries data
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != mqrb_pkg::ST_DONE |-> read_data_q == '0)
    else $error("data on failed request");
`endif

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

  // Spare request code: a valid queue ignores it and answers done
  localparam logic [mqrb_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_WORDS = 1150;
  localparam int CHUNK_WORDS  = 64;

  typedef struct packed {
    mqrb_pkg::status_e                status;
    logic [mqrb_pkg::WORD_WIDTH-1:0]  data;
  } pool_resp_t;

  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             in_valid_i   = 1'b0;
  logic                             in_ready_o;
  logic [mqrb_pkg::REQ_W-1:0]       req_type_i   = mqrb_pkg::REQ_OPEN;
  logic [mqrb_pkg::QUEUE_W-1:0]     queue_id_i   = '0;
  logic [mqrb_pkg::WORD_WIDTH-1:0]  write_data_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i  = 1'b0;
  logic [mqrb_pkg::STATUS_W-1:0]    status_o;
  logic [mqrb_pkg::WORD_WIDTH-1:0]  read_data_o;

  multi_queue_ring_buffer_pool dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .queue_id_i   (queue_id_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_data_o  (read_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the pool state
  logic [mqrb_pkg::PTR_W-1:0]       shadow_wr_ptr [mqrb_pkg::QUEUE_COUNT];
  logic [mqrb_pkg::PTR_W-1:0]       shadow_rd_ptr [mqrb_pkg::QUEUE_COUNT];
  logic [mqrb_pkg::FILL_W-1:0]      shadow_fill   [mqrb_pkg::QUEUE_COUNT];
  logic [mqrb_pkg::WORD_WIDTH-1:0]  shadow_store  [mqrb_pkg::STORE_DEPTH];

  pool_resp_t pending_resp [$];
  pool_resp_t want_resp;
  int         errors       = 0;
  int         idle_cycles  = 0;
  bit         gaps_on      = 1'b1;

  initial begin
    for (int q = 0; q < mqrb_pkg::QUEUE_COUNT; q++) begin
      shadow_wr_ptr[q] = '0;
      shadow_rd_ptr[q] = '0;
      shadow_fill[q]   = '0;
    end
  end

  function automatic logic [mqrb_pkg::PTR_W-1:0] ptr_next(
      input logic [mqrb_pkg::PTR_W-1:0] p);
    return (int'(p) == mqrb_pkg::QUEUE_DEPTH - 1) ? '0 : p + mqrb_pkg::PTR_W'(1);
  endfunction

  // Applies one request to the shadow pool and returns its response
  function automatic pool_resp_t pool_response(
      input logic [mqrb_pkg::REQ_W-1:0]      req,
      input logic [mqrb_pkg::QUEUE_W-1:0]    qid,
      input logic [mqrb_pkg::WORD_WIDTH-1:0] word);
    pool_resp_t r;
    int         q;
    r.status = mqrb_pkg::ST_DONE;
    r.data   = '0;
    if (int'(qid) >= mqrb_pkg::QUEUE_COUNT) begin
      r.status = mqrb_pkg::ST_BAD_QUEUE;
    end else begin
      q = int'(qid);
      case (req)
        mqrb_pkg::REQ_OPEN: begin
          shadow_wr_ptr[q] = '0;
          shadow_rd_ptr[q] = '0;
          shadow_fill[q]   = '0;
        end
        mqrb_pkg::REQ_PUSH: begin
          if (int'(shadow_fill[q]) >= mqrb_pkg::QUEUE_DEPTH) begin
            r.status = mqrb_pkg::ST_FULL;
          end else begin
            shadow_store[q * mqrb_pkg::QUEUE_DEPTH + int'(shadow_wr_ptr[q])] = word;
            shadow_wr_ptr[q] = ptr_next(shadow_wr_ptr[q]);
            shadow_fill[q]   = shadow_fill[q] + mqrb_pkg::FILL_W'(1);
          end
        end
        mqrb_pkg::REQ_POP: begin
          if (shadow_fill[q] == '0) begin
            r.status = mqrb_pkg::ST_EMPTY;
          end else begin
            r.data = shadow_store[q * mqrb_pkg::QUEUE_DEPTH + int'(shadow_rd_ptr[q])];
            shadow_rd_ptr[q] = ptr_next(shadow_rd_ptr[q]);
            shadow_fill[q]   = shadow_fill[q] - mqrb_pkg::FILL_W'(1);
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t tb mismatch: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  // Offers one request word and holds it until accepted
  task automatic send_word(input logic [mqrb_pkg::REQ_W-1:0]      req,
                           input logic [mqrb_pkg::QUEUE_W-1:0]    qid,
                           input logic [mqrb_pkg::WORD_WIDTH-1:0] word);
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    queue_id_i   <= qid;
    write_data_i <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_resp.push_back(pool_response(req, qid, word));
  endtask

  // Mostly short gaps, a few long ones
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Holds off until every response has come back
  task automatic drain_pool();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_resp.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_gapped(input logic [mqrb_pkg::REQ_W-1:0]      req,
                             input logic [mqrb_pkg::QUEUE_W-1:0]    qid,
                             input logic [mqrb_pkg::WORD_WIDTH-1:0] word);
    pause_sender(random_gap());
    send_word(req, qid, word);
  endtask

  // Field extremes, every request code, bad queue numbers, empty pops
  task automatic test_directed();
    send_word(mqrb_pkg::REQ_POP,  8'd0,   16'hFFFF);
    send_word(mqrb_pkg::REQ_OPEN, 8'd0,   16'hFFFF);
    send_word(mqrb_pkg::REQ_PUSH, 8'd0,   16'hFFFF);
    send_word(mqrb_pkg::REQ_PUSH, 8'd7,   16'h0000);
    send_word(mqrb_pkg::REQ_PUSH, 8'd0,   16'h8000);
    send_word(mqrb_pkg::REQ_PUSH, 8'd7,   16'h0001);
    send_word(mqrb_pkg::REQ_POP,  8'd0,   16'h0000);
    send_word(mqrb_pkg::REQ_POP,  8'd7,   16'hFFFF);
    send_word(mqrb_pkg::REQ_POP,  8'd0,   16'h5555);
    send_word(mqrb_pkg::REQ_POP,  8'd0,   16'hAAAA);
    send_word(mqrb_pkg::REQ_OPEN, 8'd8,   16'h0000);
    send_word(mqrb_pkg::REQ_PUSH, 8'd8,   16'hAAAA);
    send_word(mqrb_pkg::REQ_POP,  8'hFF,  16'hFFFF);
    send_word(mqrb_pkg::REQ_PUSH, 8'h80,  16'h5555);
    send_word(REQ_UNUSED,         8'd3,   16'hFFFF);
    send_word(REQ_UNUSED,         8'hFF,  16'h0000);
    send_word(mqrb_pkg::REQ_PUSH, 8'd3,   16'h1234);
    send_word(mqrb_pkg::REQ_OPEN, 8'd3,   16'h0000);
    send_word(mqrb_pkg::REQ_POP,  8'd3,   16'h0000);
    send_word(mqrb_pkg::REQ_POP,  8'd7,   16'h0000);
    send_word(mqrb_pkg::REQ_OPEN, 8'd7,   16'hFFFF);
    drain_pool();
  endtask

  // Fill a queue, push when full, then walk both pointers past the wrap
  task automatic test_full_wrap(input int qnum);
    logic [mqrb_pkg::QUEUE_W-1:0] qid;
    qid = mqrb_pkg::QUEUE_W'(qnum);
    send_gapped(mqrb_pkg::REQ_OPEN, qid, 16'($urandom));
    for (int i = 0; i < mqrb_pkg::QUEUE_DEPTH; i++)
      send_gapped(mqrb_pkg::REQ_PUSH, qid, 16'($urandom));
    send_gapped(mqrb_pkg::REQ_PUSH, qid, 16'hFFFF);
    for (int i = 0; i < mqrb_pkg::QUEUE_DEPTH / 2; i++)
      send_gapped(mqrb_pkg::REQ_POP, qid, 16'($urandom));
    for (int i = 0; i < mqrb_pkg::QUEUE_DEPTH / 2; i++)
      send_gapped(mqrb_pkg::REQ_PUSH, qid, 16'($urandom));
    send_gapped(mqrb_pkg::REQ_PUSH, qid, 16'h0000);
    for (int i = 0; i < mqrb_pkg::QUEUE_DEPTH; i++)
      send_gapped(mqrb_pkg::REQ_POP, qid, 16'($urandom));
    send_gapped(mqrb_pkg::REQ_POP, qid, 16'($urandom));
    // open on a partly filled queue drops its contents
    send_gapped(mqrb_pkg::REQ_PUSH, qid, 16'($urandom));
    send_gapped(mqrb_pkg::REQ_OPEN, qid, 16'($urandom));
    send_gapped(mqrb_pkg::REQ_POP, qid, 16'($urandom));
    drain_pool();
  endtask

  // Push/pop runs on a focus queue with a drifting bias, plus some noise
  task automatic test_random(input int total);
    int sent;
    int bias;
    int focus;
    int roll;
    int chunk;
    logic [mqrb_pkg::QUEUE_W-1:0] qid;
    logic [mqrb_pkg::REQ_W-1:0]   req;
    sent  = 0;
    chunk = 0;
    while (sent < total) begin
      bias    = $urandom_range(15, 85);
      focus   = $urandom_range(0, mqrb_pkg::QUEUE_COUNT - 1);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < CHUNK_WORDS && sent < total; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          req = mqrb_pkg::REQ_OPEN;
          qid = mqrb_pkg::QUEUE_W'($urandom_range(0, mqrb_pkg::QUEUE_COUNT - 1));
        end else if (roll < 12) begin
          req = mqrb_pkg::REQ_W'($urandom);
          qid = mqrb_pkg::QUEUE_W'($urandom_range(mqrb_pkg::QUEUE_COUNT, 255));
        end else if (roll < 14) begin
          req = REQ_UNUSED;
          qid = mqrb_pkg::QUEUE_W'($urandom);
        end else if (roll < 16) begin
          req = mqrb_pkg::REQ_W'($urandom);
          qid = mqrb_pkg::QUEUE_W'($urandom);
        end else begin
          req = ($urandom_range(0, 99) < bias) ? mqrb_pkg::REQ_PUSH : mqrb_pkg::REQ_POP;
          qid = ($urandom_range(0, 3) != 0)
                ? mqrb_pkg::QUEUE_W'(focus)
                : mqrb_pkg::QUEUE_W'($urandom_range(0, mqrb_pkg::QUEUE_COUNT - 1));
        end
        send_gapped(req, qid, 16'($urandom));
        sent++;
      end
      chunk++;
      if (chunk % 4 == 0) drain_pool();
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: stretches of steady ready or of random stalls, picked at random
  int ready_run  = 0;
  bit ready_rand = 1'b0;
  int stall_left = 0;
  bit ready_next;

  always @(posedge clk_i) begin
    if (ready_run == 0) begin
      ready_run  = $urandom_range(20, 200);
      ready_rand = 1'($urandom_range(0, 1));
    end
    ready_run--;
    if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if (ready_rand && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(0, 2);
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    out_ready_i <= ready_next;
  end

  // Response checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_resp.size() == 0) begin
        report_mismatch("unexpected response, read_data", 32'(read_data_o), 32'h0);
      end else begin
        want_resp = pending_resp.pop_front();
        if (status_o !== want_resp.status)
          report_mismatch("status", 32'(status_o), 32'(want_resp.status));
        if (read_data_o !== want_resp.data)
          report_mismatch("read_data", 32'(read_data_o), 32'(want_resp.data));
      end
    end
  end

  // Watchdog: no word moving on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_wrap(mqrb_pkg::QUEUE_COUNT - 1);
    test_full_wrap(2);
    test_random(RANDOM_WORDS);

    drain_pool();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending_resp.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mqrb_pkg.sv
sv/mqrb_ram.sv
sv/multi_queue_ring_buffer_pool.sv
sim/tb.sv
